FILE: rtl/dlt_pkg.sv
// shared types, constants and arithmetic helpers for the dense layer train engine
// no dependencies
package dlt_pkg;

  typedef enum logic [2:0] {
    CMD_FWD   = 3'd0,
    CMD_BWD   = 3'd1,
    CMD_UPD   = 3'd2,
    CMD_CLEAN = 3'd3,
    CMD_WR_W  = 3'd4,
    CMD_WR_B  = 3'd5
  } cmd_e;

  localparam logic [1:0] REG_NEURONS = 2'd0;
  localparam logic [1:0] REG_INPUTS  = 2'd1;
  localparam logic [1:0] REG_RATE    = 2'd2;

  localparam logic [4:0]  NEURONS_RST = 5'd16;
  localparam logic [4:0]  INPUTS_RST  = 5'd16;
  localparam logic [15:0] RATE_RST    = 16'd655;
  localparam logic [4:0]  ECNT_MAX    = 5'd31;
  localparam int          SIG_TBL_FB  = 12;

  // s(x) in q.12 at x = 0, 0.5, ... 8
  localparam logic [12:0] SIG_TBL [17] = '{
    13'd2048, 13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785, 13'd3902, 13'd3976,
    13'd4022, 13'd4051, 13'd4069, 13'd4079, 13'd4086, 13'd4090, 13'd4092, 13'd4094,
    13'd4095
  };

  function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
    logic signed [15:0] r;
    if (x > 48'sd32767) r = 16'sh7fff;
    else if (x < -48'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
    logic signed [23:0] r;
    if (x > 48'sd8388607) r = 24'sh7fffff;
    else if (x < -48'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > 48'sd2147483647) r = 32'sh7fffffff;
    else if (x < -48'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // register value clamped to 1..16 and to the build size
  function automatic logic [4:0] active_cnt(input logic [4:0] r, input int cap);
    logic [4:0] n;
    n = r;
    if (n < 5'd1) n = 5'd1;
    if (n > 5'd16) n = 5'd16;
    if (int'(n) > cap) n = 5'(cap);
    return n;
  endfunction

  // table sigmoid with linear interpolation, mirrored for negative input
  function automatic logic [15:0] sig_fx(input logic signed [15:0] z, input int fb);
    logic [16:0] a;
    logic [3:0]  idx;
    logic [16:0] fr;
    logic [29:0] t;
    logic [29:0] dl;
    a = z[15] ? 17'(-(17'(z))) : 17'(z);
    if (32'(a) >= (32'd16 << (fb - 1))) begin
      t = 30'(SIG_TBL[16]);
    end else begin
      idx = 4'(a >> (fb - 1));
      fr  = a & 17'((32'd1 << (fb - 1)) - 32'd1);
      dl  = 30'(SIG_TBL[5'(idx) + 5'd1] - SIG_TBL[idx]);
      t   = 30'(SIG_TBL[idx]) + ((dl * 30'(fr)) >> (fb - 1));
    end
    if (fb >= SIG_TBL_FB) t = t << (fb - SIG_TBL_FB);
    else t = t >> (SIG_TBL_FB - fb);
    return z[15] ? 16'((30'd1 << fb) - t) : 16'(t);
  endfunction

endpackage

FILE: rtl/dense_layer_train_engine.sv
// top level of the sigmoid dense layer train engine: sequencer, small stores, weight rams
// depends on dlt_pkg and dlt_ram
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/tready          tdata, tuser (cmd), tlast (last)
// m_axis   out  m_axis_tvalid/tready          tdata, tuser (kind), tlast (end_of_run)
// cfg      in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// forward: an entry per active neuron, bias and emit per neuron if last; backward: sigmoid,
// derivative, gradient, emit, an entry per active input; update: per weight, bias per neuron
// clean and reset: one weight delta ram entry per cycle, all NEURONS*INPUTS, no input taken
// each fwd, bwd and upd entry goes through a read, multiply, write step on the single ram ports
// a stalled result holds the sequencer in its emit step; input is taken only when idle
module dense_layer_train_engine import dlt_pkg::*; #(
  parameter int NEURONS   = 16,
  parameter int INPUTS    = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // neuron_index, input_index, value
  input  logic [2:0]  s_axis_tuser,  // cmd
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // neuron_out, result_value, zero pad
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast,  // end_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int DEPTH = NEURONS * INPUTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int IW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_FWD_RD   = 20'h00002,
    S_FWD_MUL  = 20'h00004,
    S_FWD_WR   = 20'h00008,
    S_ACT_Z    = 20'h00010,
    S_ACT_OUT  = 20'h00020,
    S_BWD_SIG  = 20'h00040,
    S_BWD_DER  = 20'h00080,
    S_BWD_G    = 20'h00100,
    S_BWD_OUT  = 20'h00200,
    S_BWD_RD   = 20'h00400,
    S_BWD_MUL  = 20'h00800,
    S_BWD_WR   = 20'h01000,
    S_UPD_RD   = 20'h02000,
    S_UPD_MUL  = 20'h04000,
    S_UPD_WR   = 20'h08000,
    S_UPD_BMUL = 20'h10000,
    S_UPD_BWR  = 20'h20000,
    S_CLR      = 20'h40000,
    S_SPARE    = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic [4:0]  i_q, i_d, j_q, j_d;
  logic [AW:0] clr_q, clr_d;
  logic [4:0]  ecnt_q;
  logic [4:0]  nreg_q, ireg_q;
  logic [15:0] lr_q;

  logic [2:0]  cmd_in;
  logic [3:0]  ni_in, ii_in;
  logic signed [15:0] v_in;

  logic [3:0]  ni_q, ii_q;
  logic signed [15:0] v_q;
  logic        last_q;

  logic signed [31:0] sum_q  [NEURONS];
  logic signed [15:0] bias_q [NEURONS];
  logic signed [23:0] bd_q   [NEURONS];
  logic signed [15:0] in_q   [INPUTS];

  logic signed [31:0] p_q;
  logic signed [15:0] z_q, g_q;
  logic [15:0] s_q, sp_q;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_n_q;
  logic [15:0] out_v_q;
  logic        out_kind_q, out_eor_q;

  logic        acc, free, emit_act, emit_bwd;
  logic [4:0]  nn, mm;
  logic [3:0]  row;
  logic [4:0]  col;
  logic [AW-1:0] k_addr, win_addr;
  logic        w_we, w_re, wd_we, wd_re;
  logic [AW-1:0] w_waddr, wd_waddr;
  logic [15:0] w_wdata, w_rd;
  logic [23:0] wd_wdata, wd_rd;
  logic        fwd_in, wr_w_ok;

  assign cmd_in = s_axis_tuser;
  assign ni_in  = s_axis_tdata[3:0];
  assign ii_in  = s_axis_tdata[7:4];
  assign v_in   = s_axis_tdata[23:8];

  assign nn = active_cnt(nreg_q, NEURONS);
  assign mm = active_cnt(ireg_q, INPUTS);

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign free          = ~out_valid_q | m_axis_tready;
  assign emit_act      = (state_q == S_ACT_OUT) & free;
  assign emit_bwd      = (state_q == S_BWD_OUT) & free;
  assign fwd_in        = 5'(ii_in) < mm;
  assign wr_w_ok       = (int'(ni_in) < NEURONS) && (int'(ii_in) < INPUTS);

  // ram addressing
  always_comb begin
    row = (state_q == S_BWD_RD || state_q == S_BWD_WR) ? ni_q : 4'(i_q);
    col = (state_q == S_FWD_RD) ? 5'(ii_q) : j_q;
    k_addr   = AW'(int'(row) * INPUTS + int'(col));
    win_addr = AW'(int'(ni_in) * INPUTS + int'(ii_in));
  end

  assign w_re     = (state_q == S_FWD_RD) | (state_q == S_UPD_RD);
  assign w_we     = (acc & (cmd_e'(cmd_in) == CMD_WR_W) & wr_w_ok) | (state_q == S_UPD_WR);
  assign w_waddr  = (state_q == S_UPD_WR) ? k_addr : win_addr;
  assign w_wdata  = (state_q == S_UPD_WR)
                  ? sat16(48'(signed'(w_rd)) - 48'(p_q)) : v_in;
  assign wd_re    = (state_q == S_BWD_RD) | (state_q == S_UPD_RD);
  assign wd_we    = (state_q == S_BWD_WR) | (state_q == S_CLR);
  assign wd_waddr = (state_q == S_CLR) ? clr_q[AW-1:0] : k_addr;
  assign wd_wdata = (state_q == S_CLR) ? 24'd0
                  : sat24(48'(signed'(wd_rd)) + 48'(p_q));

  dlt_ram #(.W(16), .DEPTH(DEPTH)) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (k_addr),
    .rdata_o (w_rd)
  );

  dlt_ram #(.W(24), .DEPTH(DEPTH)) u_wd_ram (
    .clk_i   (clk_i),
    .we_i    (wd_we),
    .waddr_i (wd_waddr),
    .wdata_i (wd_wdata),
    .re_i    (wd_re),
    .raddr_i (k_addr),
    .rdata_o (wd_rd)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          i_d = '0;
          j_d = '0;
          case (cmd_e'(cmd_in))
            CMD_FWD: begin
              if (fwd_in) state_d = S_FWD_RD;
              else if (s_axis_tlast) state_d = S_ACT_Z;
            end
            CMD_BWD: begin
              if (5'(ni_in) < nn) state_d = S_BWD_SIG;
            end
            CMD_UPD: state_d = S_UPD_RD;
            CMD_CLEAN: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_FWD_RD:  state_d = S_FWD_MUL;
      S_FWD_MUL: state_d = S_FWD_WR;
      S_FWD_WR: begin
        if (i_q + 5'd1 < nn) begin
          i_d     = i_q + 5'd1;
          state_d = S_FWD_RD;
        end else if (last_q) begin
          i_d     = '0;
          state_d = S_ACT_Z;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ACT_Z: state_d = S_ACT_OUT;
      S_ACT_OUT: begin
        if (free) begin
          if (i_q + 5'd1 < nn) begin
            i_d     = i_q + 5'd1;
            state_d = S_ACT_Z;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_BWD_SIG: state_d = S_BWD_DER;
      S_BWD_DER: state_d = S_BWD_G;
      S_BWD_G:   state_d = S_BWD_OUT;
      S_BWD_OUT: begin
        if (free) begin
          j_d     = '0;
          state_d = S_BWD_RD;
        end
      end
      S_BWD_RD:  state_d = S_BWD_MUL;
      S_BWD_MUL: state_d = S_BWD_WR;
      S_BWD_WR: begin
        if (j_q + 5'd1 < mm) begin
          j_d     = j_q + 5'd1;
          state_d = S_BWD_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_UPD_RD:  state_d = S_UPD_MUL;
      S_UPD_MUL: state_d = S_UPD_WR;
      S_UPD_WR: begin
        if (j_q + 5'd1 < mm) begin
          j_d     = j_q + 5'd1;
          state_d = S_UPD_RD;
        end else begin
          j_d     = '0;
          state_d = S_UPD_BMUL;
        end
      end
      S_UPD_BMUL: state_d = S_UPD_BWR;
      S_UPD_BWR: begin
        if (i_q + 5'd1 < nn) begin
          i_d     = i_q + 5'd1;
          state_d = S_UPD_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(DEPTH - 1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = emit_act | emit_bwd | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      i_q         <= '0;
      j_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      nreg_q      <= NEURONS_RST;
      ireg_q      <= INPUTS_RST;
      lr_q        <= RATE_RST;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_NEURONS: nreg_q <= cfg_data_i[4:0];
          REG_INPUTS:  ireg_q <= cfg_data_i[4:0];
          REG_RATE:    lr_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // element count, sums and bias deltas
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_q <= '0;
      for (int n = 0; n < NEURONS; n++) begin
        sum_q[n] <= '0;
        bd_q[n]  <= '0;
      end
    end else begin
      if (acc && cmd_e'(cmd_in) == CMD_FWD) begin
        if (ecnt_q == 5'd0) begin
          for (int n = 0; n < NEURONS; n++) sum_q[n] <= '0;
        end
        if (s_axis_tlast) ecnt_q <= '0;
        else if (ecnt_q < ECNT_MAX) ecnt_q <= ecnt_q + 5'd1;
      end
      if (acc && cmd_e'(cmd_in) == CMD_CLEAN) begin
        for (int n = 0; n < NEURONS; n++) bd_q[n] <= '0;
      end
      if (state_q == S_FWD_WR) begin
        sum_q[NW'(i_q)] <= sat32(48'(sum_q[NW'(i_q)]) + 48'(p_q));
      end
      if (state_q == S_ACT_Z) begin
        sum_q[NW'(i_q)] <= 32'(sat16(48'(sum_q[NW'(i_q)]) + 48'(bias_q[NW'(i_q)])));
      end
      if (emit_bwd) begin
        bd_q[NW'(ni_q)] <= sat24(48'(bd_q[NW'(ni_q)]) + 48'(g_q));
      end
    end
  end

  // payload registers and arithmetic steps
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ni_q   <= ni_in;
      ii_q   <= ii_in;
      v_q    <= v_in;
      last_q <= s_axis_tlast;
      if (cmd_e'(cmd_in) == CMD_FWD && fwd_in) in_q[IW'(ii_in)] <= v_in;
      if (cmd_e'(cmd_in) == CMD_WR_B && int'(ni_in) < NEURONS) bias_q[NW'(ni_in)] <= v_in;
    end
    case (state_q)
      S_FWD_MUL: p_q <= (signed'(w_rd) * v_q) >>> FRAC_BITS;
      S_ACT_Z:   z_q <= sat16(48'(sum_q[NW'(i_q)]) + 48'(bias_q[NW'(i_q)]));
      S_BWD_SIG: s_q <= sig_fx(sat16(48'(sum_q[NW'(ni_q)])), FRAC_BITS);
      S_BWD_DER: sp_q <= 16'((32'(s_q) * (32'(1) << FRAC_BITS) - 32'(s_q) * 32'(s_q))
                             >> FRAC_BITS);
      S_BWD_G:   g_q <= sat16((48'(v_q) * 48'(signed'({1'b0, sp_q}))) >>> FRAC_BITS);
      S_BWD_MUL: p_q <= (g_q * in_q[IW'(j_q)]) >>> FRAC_BITS;
      S_UPD_MUL: p_q <= 32'((48'(signed'(wd_rd)) * 48'(signed'({1'b0, lr_q}))) >>> 16);
      S_UPD_BMUL: p_q <= 32'((48'(bd_q[NW'(i_q)]) * 48'(signed'({1'b0, lr_q}))) >>> 16);
      S_UPD_BWR: bias_q[NW'(i_q)] <= sat16(48'(bias_q[NW'(i_q)]) - 48'(p_q));
      default: ;
    endcase
    if (emit_act) begin
      out_kind_q <= 1'b0;
      out_n_q    <= 4'(i_q);
      out_v_q    <= sig_fx(z_q, FRAC_BITS);
      out_eor_q  <= (i_q + 5'd1 == nn);
    end else if (emit_bwd) begin
      out_kind_q <= 1'b1;
      out_n_q    <= ni_q;
      out_v_q    <= g_q;
      out_eor_q  <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_v_q, out_n_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_eor_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == S_IDLE && !wd_we))
    else $error("input taken while sequencer busy");

  a_clean_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_e'(cmd_in) == CMD_CLEAN) |=> (state_q == S_CLR && clr_q == '0))
    else $error("clean did not start delta sweep");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_v_q)))
    else $error("pending result overwritten");

endmodule

FILE: rtl/dlt_ram.sv
// single port write, single port read synchronous ram, read data registered
// depends on nothing
module dlt_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
